>>> src/vtqp_pkg.sv
`default_nettype none
package vtqp_pkg;
    localparam int DEF_SCREEN_WIDTH  = 512;
    localparam int DEF_SCREEN_HEIGHT = 512;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int SINE_BITS = 16;

    localparam logic [2:0] REG_SCALE_X   = 3'd0;
    localparam logic [2:0] REG_SCALE_Y   = 3'd1;
    localparam logic [2:0] REG_SCALE_Z   = 3'd2;
    localparam logic [2:0] REG_ROT_AXIS  = 3'd3;
    localparam logic [2:0] REG_ROT_ANGLE = 3'd4;
    localparam logic [2:0] REG_SHEAR     = 3'd5;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic [1:0]         rot_axis;
        logic [8:0]         rot_angle;
        logic signed [23:0] shear;
    } cfg_t;

    // quarter-wave sine, q1.16
    function automatic logic [16:0] sine_tab(input logic [6:0] i);
        logic [16:0] t;
        unique case (i)
            7'd0: t=17'd0; 7'd1: t=17'd1144; 7'd2: t=17'd2287; 7'd3: t=17'd3430;
            7'd4: t=17'd4572; 7'd5: t=17'd5712; 7'd6: t=17'd6850; 7'd7: t=17'd7987;
            7'd8: t=17'd9121; 7'd9: t=17'd10252; 7'd10: t=17'd11380; 7'd11: t=17'd12505;
            7'd12: t=17'd13626; 7'd13: t=17'd14742; 7'd14: t=17'd15855;
            7'd15: t=17'd16962; 7'd16: t=17'd18064; 7'd17: t=17'd19161;
            7'd18: t=17'd20252; 7'd19: t=17'd21336; 7'd20: t=17'd22415;
            7'd21: t=17'd23486; 7'd22: t=17'd24550; 7'd23: t=17'd25607;
            7'd24: t=17'd26656; 7'd25: t=17'd27697; 7'd26: t=17'd28729;
            7'd27: t=17'd29753; 7'd28: t=17'd30767; 7'd29: t=17'd31772;
            7'd30: t=17'd32768; 7'd31: t=17'd33754; 7'd32: t=17'd34729;
            7'd33: t=17'd35693; 7'd34: t=17'd36647; 7'd35: t=17'd37590;
            7'd36: t=17'd38521; 7'd37: t=17'd39441; 7'd38: t=17'd40348;
            7'd39: t=17'd41243; 7'd40: t=17'd42126; 7'd41: t=17'd42995;
            7'd42: t=17'd43852; 7'd43: t=17'd44695; 7'd44: t=17'd45525;
            7'd45: t=17'd46341; 7'd46: t=17'd47143; 7'd47: t=17'd47930;
            7'd48: t=17'd48703; 7'd49: t=17'd49461; 7'd50: t=17'd50203;
            7'd51: t=17'd50931; 7'd52: t=17'd51643; 7'd53: t=17'd52339;
            7'd54: t=17'd53020; 7'd55: t=17'd53684; 7'd56: t=17'd54332;
            7'd57: t=17'd54963; 7'd58: t=17'd55578; 7'd59: t=17'd56175;
            7'd60: t=17'd56756; 7'd61: t=17'd57319; 7'd62: t=17'd57865;
            7'd63: t=17'd58393; 7'd64: t=17'd58903; 7'd65: t=17'd59396;
            7'd66: t=17'd59870; 7'd67: t=17'd60326; 7'd68: t=17'd60764;
            7'd69: t=17'd61183; 7'd70: t=17'd61584; 7'd71: t=17'd61966;
            7'd72: t=17'd62328; 7'd73: t=17'd62672; 7'd74: t=17'd62997;
            7'd75: t=17'd63303; 7'd76: t=17'd63589; 7'd77: t=17'd63856;
            7'd78: t=17'd64104; 7'd79: t=17'd64332; 7'd80: t=17'd64540;
            7'd81: t=17'd64729; 7'd82: t=17'd64898; 7'd83: t=17'd65048;
            7'd84: t=17'd65177; 7'd85: t=17'd65287; 7'd86: t=17'd65376;
            7'd87: t=17'd65446; 7'd88: t=17'd65496; 7'd89: t=17'd65526;
            7'd90: t=17'd65536;
            default: t = 17'd0;
        endcase
        return t;
    endfunction

    // sine of a whole-degree angle below 360, q1.16 signed
    function automatic logic signed [17:0] sin_deg(input logic [8:0] d);
        logic [1:0]  q;
        logic [6:0]  r;
        logic [16:0] t;
        if (d >= 9'd270) begin
            q = 2'd3; r = 7'(d - 9'd270);
        end else if (d >= 9'd180) begin
            q = 2'd2; r = 7'(d - 9'd180);
        end else if (d >= 9'd90) begin
            q = 2'd1; r = 7'(d - 9'd90);
        end else begin
            q = 2'd0; r = d[6:0];
        end
        t = q[0] ? sine_tab(7'd90 - r) : sine_tab(r);
        return q[1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

>>> src/vtqp_xform.sv
`default_nettype none
// scale, rotate, shear; six register stages
module vtqp_xform #(
    parameter int FRACTION_BITS = vtqp_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire vtqp_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    input  wire logic signed [23:0]  in_x,
    input  wire logic signed [23:0]  in_y,
    input  wire logic signed [23:0]  in_z,
    input  wire logic                in_last,
    output logic                     out_valid,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output logic                     out_last
);
    import vtqp_pkg::*;

    logic [4:0] v_reg;
    logic [4:0] l_reg;

    // stage 1: scale products
    logic signed [47:0] px_reg, py_reg, pz_reg;
    // stage 2: rounded scale, trig
    logic signed [31:0] xs_reg, ys_reg, zs_reg;
    logic signed [17:0] c_reg, s_reg;
    // stage 3: rotation products
    logic signed [49:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [31:0] xs3_reg, ys3_reg;
    // stage 4: rotated
    logic signed [31:0] xr_reg, yr_reg;
    // stage 5
    logic signed [31:0] xh_reg, yr5_reg;
    logic signed [56:0] sh_reg;
    logic signed [31:0] xr5_reg;

    logic [8:0] ang;
    logic [8:0] ang90;
    logic signed [31:0] xr_next, yr_next;
    logic signed [63:0] sum0, sum1;

    function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                               input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    always_comb begin
        ang   = (cfg.rot_angle >= 9'd360) ? cfg.rot_angle - 9'd360 : cfg.rot_angle;
        ang90 = (ang >= 9'd270) ? ang - 9'd270 : ang + 9'd90;
    end

    always_comb begin
        xr_next = xs3_reg;
        yr_next = ys3_reg;
        sum0 = 64'(m0_reg) - 64'(m1_reg);
        sum1 = 64'(m2_reg) + 64'(m3_reg);
        unique case (cfg.rot_axis)
            AXIS_X: yr_next = sat32(rsh(sum0, SINE_BITS));
            AXIS_Y: xr_next = sat32(rsh(sum1, SINE_BITS));
            AXIS_Z: begin
                xr_next = sat32(rsh(sum0, SINE_BITS));
                yr_next = sat32(rsh(sum1, SINE_BITS));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg  <= {l_reg[3:0], in_last};
            px_reg <= cfg.scale_x * in_x;
            py_reg <= cfg.scale_y * in_y;
            pz_reg <= cfg.scale_z * in_z;

            xs_reg <= sat32(rsh(64'(px_reg), FRACTION_BITS));
            ys_reg <= sat32(rsh(64'(py_reg), FRACTION_BITS));
            zs_reg <= sat32(rsh(64'(pz_reg), FRACTION_BITS));
            c_reg  <= sin_deg(ang90);
            s_reg  <= -sin_deg(ang);

            // x axis: m0=c*ys m1=s*zs; y: m2=c*xs m3=s*zs; z: m0=c*xs m1=s*ys m2=s*xs m3=c*ys
            xs3_reg <= xs_reg;
            ys3_reg <= ys_reg;
            m0_reg <= c_reg * ((cfg.rot_axis == AXIS_X) ? ys_reg : xs_reg);
            m1_reg <= s_reg * ((cfg.rot_axis == AXIS_X) ? zs_reg : ys_reg);
            m2_reg <= ((cfg.rot_axis == AXIS_Z) ? s_reg : c_reg) * xs_reg;
            m3_reg <= ((cfg.rot_axis == AXIS_Z) ? c_reg : s_reg) *
                      ((cfg.rot_axis == AXIS_Z) ? ys_reg : zs_reg);

            xr_reg <= xr_next;
            yr_reg <= yr_next;

            sh_reg  <= cfg.shear * yr_reg;
            xr5_reg <= xr_reg;
            yr5_reg <= yr_reg;

            xh_reg <= sat32(64'(xr5_reg) + rsh(64'(sh_reg), FRACTION_BITS));
        end
    end

    // final stage valid aligns with xh_reg
    logic v6_reg, l6_reg;
    logic signed [31:0] y6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en) v6_reg <= v_reg[4];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            l6_reg <= l_reg[4];
            y6_reg <= yr5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_x     = xh_reg;
    assign out_y     = y6_reg;
    assign out_last  = l6_reg;
endmodule
`default_nettype wire

>>> src/vtqp_quad.sv
`default_nettype none
// quadrant sequencer and pixel mapping, one point per cycle while a vertex is offered and the output is not stalled
module vtqp_quad #(
    parameter int SCREEN_WIDTH  = vtqp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = vtqp_pkg::DEF_SCREEN_HEIGHT,
    parameter int FRACTION_BITS = vtqp_pkg::DEF_FRACTION_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [39:0]            out_data
);
    localparam logic signed [47:0] ONE  = 48'sd1 <<< FRACTION_BITS;
    localparam logic signed [47:0] HALF = 48'sd1 <<< (FRACTION_BITS - 1);

    logic [1:0] q_reg, q_next;
    logic       busy;
    logic signed [47:0] vx, vy, nx, ny;
    logic signed [63:0] mx, my, px, py;
    logic signed [15:0] sx, sy;
    logic sat;
    logic ov_reg, ov_next;
    logic [39:0] od_reg, od_next;
    logic take;

    // per-vertex hold: keep the vertex until its fourth quadrant point is taken
    assign take     = in_valid && (!ov_reg || out_ready);
    assign in_ready = take && (q_reg == 2'd3);

    function automatic logic signed [63:0] tdiv(input logic signed [63:0] n,
                                                input int sh);
        // truncate toward zero by a power of two
        logic signed [63:0] b;
        b = (n < 0) ? n + ((64'sd1 <<< sh) - 64'sd1) : n;
        return b >>> sh;
    endfunction

    always_comb begin
        vx = q_reg[0] ? -48'(in_x) + HALF : 48'(in_x) - HALF;
        vy = q_reg[1] ? -48'(in_y) - HALF : 48'(in_y) + HALF;
        nx = vx + ONE;
        ny = ONE - vy;
        mx = 64'(nx) * 64'(SCREEN_WIDTH);
        my = 64'(ny) * 64'(SCREEN_HEIGHT);
        px = tdiv(mx, FRACTION_BITS + 1);
        py = tdiv(my, FRACTION_BITS + 1);
        sat = 1'b0;
        if (px > 64'sd32767) begin sx = 16'sh7fff; sat = 1'b1; end
        else if (px < -64'sd32768) begin sx = 16'sh8000; sat = 1'b1; end
        else sx = px[15:0];
        if (py > 64'sd32767) begin sy = 16'sh7fff; sat = 1'b1; end
        else if (py < -64'sd32768) begin sy = 16'sh8000; sat = 1'b1; end
        else sy = py[15:0];
        busy    = 1'b0;
        q_next  = q_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        if (take) begin
            q_next  = q_reg + 2'd1;
            ov_next = 1'b1;
            od_next = {3'b000, sat, (q_reg == 2'd3) && in_last,
                       q_reg == 2'd3, q_reg, sy, sx};
            busy = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg  <= 2'd0;
            ov_reg <= 1'b0;
        end else begin
            q_reg  <= q_next;
            ov_reg <= ov_next;
        end
    end
    always_ff @(posedge aclk) begin
        if (busy) od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule
`default_nettype wire

>>> src/vertex_transform_quadrant_project.sv
`default_nettype none
// channel   | direction | data (lsb first)
// s_axis    | in        | tdata vertex_x, vertex_y, vertex_z; tlast last_vertex
// m_axis    | out       | tdata screen_x, screen_y, quadrant, saturated; tlast, tuser
// cfg       | in        | cfg_we, cfg_index, cfg_data
// an accepted word passes the six transform stages plus the output register before
// its first point; then one point per cycle while m_axis is not stalled
// vertex throughput is bounded by the four-point emitter
// aresetn synchronous, active low; registers return to unit scale, no rotation
// a stall on m_axis holds the emitter; the transform pipeline freezes with its
// valid bits once a vertex waits at its tail
module vertex_transform_quadrant_project #(
    parameter int SCREEN_WIDTH  = vtqp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = vtqp_pkg::DEF_SCREEN_HEIGHT,
    parameter int FRACTION_BITS = vtqp_pkg::DEF_FRACTION_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    input  wire logic        s_tlast,   // last_vertex
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // screen_x, screen_y, quadrant, saturated, pad
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser,   // end_of_mesh
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import vtqp_pkg::*;

    cfg_t cfg_reg;
    logic en;
    logic xv, q_ready;
    logic signed [31:0] xx, xy;
    logic xl;
    logic [39:0] qd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_x   <= 24'sd1 <<< FRACTION_BITS;
            cfg_reg.scale_y   <= 24'sd1 <<< FRACTION_BITS;
            cfg_reg.scale_z   <= 24'sd1 <<< FRACTION_BITS;
            cfg_reg.rot_axis  <= AXIS_NONE;
            cfg_reg.rot_angle <= 9'd0;
            cfg_reg.shear     <= 24'sd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCALE_X:   cfg_reg.scale_x   <= cfg_data;
                REG_SCALE_Y:   cfg_reg.scale_y   <= cfg_data;
                REG_SCALE_Z:   cfg_reg.scale_z   <= cfg_data;
                REG_ROT_AXIS:  cfg_reg.rot_axis  <= cfg_data[1:0];
                REG_ROT_ANGLE: cfg_reg.rot_angle <= cfg_data[8:0];
                REG_SHEAR:     cfg_reg.shear     <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished vertex waits at its tail
    assign en       = !xv || q_ready;
    assign s_tready = en;

    vtqp_xform #(.FRACTION_BITS(FRACTION_BITS)) u_xform (
        .aclk(aclk), .aresetn(aresetn), .en(en), .cfg(cfg_reg),
        .in_valid(s_tvalid && en),
        .in_x(s_tdata[23:0]), .in_y(s_tdata[47:24]), .in_z(s_tdata[71:48]),
        .in_last(s_tlast),
        .out_valid(xv), .out_x(xx), .out_y(xy), .out_last(xl)
    );

    vtqp_quad #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_quad (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(xv), .in_ready(q_ready),
        .in_x(xx), .in_y(xy), .in_last(xl),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(qd)
    );

    // quad packs {pad, sat, eom, lor, quadrant, sy, sx}
    assign m_tdata = {5'b0, qd[36], qd[33:32], qd[31:0]};
    assign m_tlast = qd[34];
    assign m_tuser = qd[35];
endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import vtqp_pkg::*;

    localparam longint ONE  = 64'sd1 << DEF_FRACTION_BITS;
    localparam longint HALF = 64'sd1 << (DEF_FRACTION_BITS - 1);

    // quarter-wave sine, q1.16, one entry per degree
    localparam int QUARTER_SINE [0:90] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [1:0]         quad;
        logic               run_end;
        logic               mesh_end;
        logic               clamped;
    } screen_point_t;

    // directed vertex; typed points apply to quadrants 0..3 when known is set
    typedef struct {
        logic signed [23:0] x, y, z;
        logic               last;
        bit                 known;
        int                 px [4];
        int                 py [4];
    } vertex_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // vertex_x, vertex_y, vertex_z
    logic        s_tlast = 1'b0;  // last_vertex
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // screen_x, screen_y, quadrant, saturated, pad
    logic        m_tlast;         // last_of_run
    logic        m_tuser;         // end_of_mesh
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_SCALE_X;
    logic [23:0] cfg_data = '0;

    vertex_transform_quadrant_project dut (.*);

    // local copy of the register file
    longint     gain_x, gain_y, gain_z, shear_gain;
    logic [1:0] spin_axis;
    logic [8:0] spin_deg;

    screen_point_t pending_points [$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint sine_of(int d);
        int q, r;
        longint t;
        q = (d / 90) & 3;
        r = d % 90;
        t = (q & 1) ? QUARTER_SINE[90 - r] : QUARTER_SINE[r];
        return (q & 2) ? -t : t;
    endfunction

    // round half up, floor shift
    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip16(longint v, ref logic hit);
        if (v > 32767) begin
            hit = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            hit = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // scale, rotate, shear, then four mirrored viewport copies
    task automatic project_vertex(logic signed [23:0] x, y, z, logic last);
        longint xs, ys, zs, c, s, xr, yr, xh, vx, vy, px, py;
        int a;
        screen_point_t p;
        xs = clip32(rnd_shift(gain_x * x, DEF_FRACTION_BITS));
        ys = clip32(rnd_shift(gain_y * y, DEF_FRACTION_BITS));
        zs = clip32(rnd_shift(gain_z * z, DEF_FRACTION_BITS));
        a = spin_deg % 360;
        c = sine_of((a + 90) % 360);
        s = -sine_of(a);
        xr = xs;
        yr = ys;
        case (spin_axis)
            AXIS_X: yr = clip32(rnd_shift(c * ys - s * zs, SINE_BITS));
            AXIS_Y: xr = clip32(rnd_shift(c * xs + s * zs, SINE_BITS));
            AXIS_Z: begin
                xr = clip32(rnd_shift(c * xs - s * ys, SINE_BITS));
                yr = clip32(rnd_shift(s * xs + c * ys, SINE_BITS));
            end
            default: ;
        endcase
        xh = clip32(xr + rnd_shift(shear_gain * yr, DEF_FRACTION_BITS));
        for (int r = 0; r < 4; r++) begin
            vx = r[0] ? HALF - xh : xh - HALF;
            vy = r[1] ? -yr - HALF : yr + HALF;
            p.clamped = 1'b0;
            px = ((vx + ONE) * DEF_SCREEN_WIDTH) / (2 * ONE);
            py = ((ONE - vy) * DEF_SCREEN_HEIGHT) / (2 * ONE);
            p.sx = 16'(clip16(px, p.clamped));
            p.sy = 16'(clip16(py, p.clamped));
            p.quad = 2'(r);
            p.run_end = (r == 3);
            p.mesh_end = (r == 3) && last;
            pending_points.push_back(p);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SCALE_X:   gain_x = longint'($signed(val));
            REG_SCALE_Y:   gain_y = longint'($signed(val));
            REG_SCALE_Z:   gain_z = longint'($signed(val));
            REG_ROT_AXIS:  spin_axis = val[1:0];
            REG_ROT_ANGLE: spin_deg = val[8:0];
            REG_SHEAR:     shear_gain = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_transform(logic [23:0] kx, ky, kz, logic [1:0] ax,
                                 logic [8:0] deg, logic [23:0] sh);
        write_reg(REG_SCALE_X, kx);
        write_reg(REG_SCALE_Y, ky);
        write_reg(REG_SCALE_Z, kz);
        write_reg(REG_ROT_AXIS, {22'd0, ax});
        write_reg(REG_ROT_ANGLE, {15'd0, deg});
        write_reg(REG_SHEAR, sh);
        cfg_we <= 1'b0;
    endtask

    // wait out every pending point plus the pipeline depth
    task automatic drain();
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // offer one word and hold it until taken
    task automatic send_vertex(logic signed [23:0] x, y, z, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(int count);
        logic signed [23:0] x, y, z;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                // full range reaches saturation and every bit
                x = 24'($urandom);
                y = 24'($urandom);
                z = 24'($urandom);
            end else begin
                // mostly on-screen coordinates
                x = 24'($signed($urandom_range(131072)) - 65536);
                y = 24'($signed($urandom_range(131072)) - 65536);
                z = 24'($signed($urandom_range(131072)) - 65536);
            end
            send_vertex(x, y, z, $urandom_range(7) == 0);
            project_vertex(x, y, z, s_tlast);
        end
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each taken word against the oldest pending point
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                $display("%t unexpected word %h last %b user %b", $time, m_tdata,
                         m_tlast, m_tuser);
                errors++;
            end else begin
                screen_point_t e;
                e = pending_points.pop_front();
                if (m_tdata[15:0] !== e.sx || m_tdata[31:16] !== e.sy
                    || m_tdata[33:32] !== e.quad || m_tdata[34] !== e.clamped
                    || m_tlast !== e.run_end || m_tuser !== e.mesh_end) begin
                    $display("%t expected x %0d y %0d q %0d sat %b last %b eom %b", $time,
                             e.sx, e.sy, e.quad, e.clamped, e.run_end, e.mesh_end);
                    $display("%t actual   x %0d y %0d q %0d sat %b last %b eom %b", $time,
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                             m_tdata[33:32], m_tdata[34], m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    vertex_row_t directed [] = '{
        // origin at reset: quadrant centers of the screen
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, 1, '{128, 384, 128, 384}, '{128, 128, 384, 384}},
        '{24'sh7fffff, 24'sd0, 24'sd0, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{24'sh800000, 24'sd0, 24'sd0, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{24'sd0, 24'sh7fffff, 24'sh800000, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{24'sd0, 24'sh800000, 24'sh7fffff, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{24'sd65536, 24'sd65536, 24'sd65536, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{-24'sd65536, -24'sd32768, 24'sd12345, 1'b0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b1, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}}
    };

    initial begin
        gain_x = ONE; gain_y = ONE; gain_z = ONE;
        spin_axis = AXIS_NONE; spin_deg = 9'd0; shear_gain = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset settings, no idling
        foreach (directed[i]) begin
            send_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].last);
            if (directed[i].known) begin
                for (int r = 0; r < 4; r++)
                    pending_points.push_back('{16'(directed[i].px[r]), 16'(directed[i].py[r]),
                                               2'(r), r == 3, (r == 3) && directed[i].last,
                                               1'b0});
            end else begin
                project_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].last);
            end
        end
        s_tvalid <= 1'b0;
        drain();

        // each axis, angle wrap past 360, scale and shear extremes
        set_transform(24'd65536, 24'd65536, 24'd65536, AXIS_Z, 9'd30, 24'd16384);
        send_random(4);
        drain();
        set_transform(24'h7fffff, 24'h800000, 24'd65536, AXIS_X, 9'd359, 24'h7fffff);
        send_random(4);
        drain();
        set_transform(24'h800000, 24'h7fffff, 24'h800000, AXIS_Y, 9'd511, 24'h800000);
        send_random(4);
        drain();
        set_transform(24'd32768, 24'd65536, 24'd0, AXIS_Z, 9'd90, 24'd0);
        send_random(4);
        drain();

        // random settings across the idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            set_transform(rand_gain(), rand_gain(), rand_gain(), 2'($urandom_range(3)),
                          9'($urandom_range(511)), rand_gain());
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            if (ph == 2) hold_req = 1;  // long receiver hold-off, sender keeps offering
            // more words than the pipeline holds while the receiver is held off
            send_random((ph == 2) ? 10 : 6);
            // sender pauses until everything is out, then resumes
            while (pending_points.size() != 0) @(posedge aclk);
            send_random(5);
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
